// ===== sv/ami_pkg.sv =====
// Shared types and codes for the affine matrix inverter.
`default_nettype none

package ami_pkg;

  // Result status codes carried on the result channel.
  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_SINGULAR = 2'd1,
    ST_OVERFLOW = 2'd2
  } status_t;

  // Per-word control flags that travel alongside the quotient lanes.
  typedef struct packed {
    logic       singular;
    logic [3:0] neg;
    logic [3:0] big;
  } ctl_t;

endpackage

`default_nettype wire

// ===== sv/ami_prep.sv =====
// Determinant and divider operand preparation: three register stages.
`default_nettype none

module ami_prep #(
  parameter int W = 32,
  parameter int F = 16
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  en,
  input  wire logic                  vld_in,
  input  wire logic signed [W-1:0]   xx,
  input  wire logic signed [W-1:0]   xy,
  input  wire logic signed [W-1:0]   yx,
  input  wire logic signed [W-1:0]   yy,
  input  wire logic signed [W-1:0]   tx,
  input  wire logic signed [W-1:0]   ty,
  output logic                       vld_out,
  output logic [W+2*F-1:0]           num_out [4],
  output logic [2*W-1:0]             den_out,
  output ami_pkg::ctl_t              ctl_out,
  output logic [2*W-1:0]             sb_out
);

  localparam int NW = W + 2*F;
  localparam int DW = 2*W;
  localparam int CW = 3*W;

  // Stage one: the two cross products.
  logic                 v1_r;
  logic signed [DW-1:0] pa_r, pb_r;
  logic signed [W-1:0]  xx1_r, xy1_r, yx1_r, yy1_r;
  logic [DW-1:0]        sb1_r;

  // Stage two: the determinant, kept exactly.
  logic                 v2_r;
  logic signed [DW:0]   det_r;
  logic signed [W-1:0]  xx2_r, xy2_r, yx2_r, yy2_r;
  logic [DW-1:0]        sb2_r;

  // Stage three: magnitudes, signs and the quotient range check.
  logic                 v3_r;
  logic [NW-1:0]        num_r [4];
  logic [DW-1:0]        den_r;
  ami_pkg::ctl_t        ctl_r;
  logic [DW-1:0]        sb3_r;

  logic signed [DW:0]   det_nxt;
  logic [DW:0]          dabs;
  logic [DW-1:0]        den_nxt;
  logic signed [W:0]    nsg [4];
  logic [W:0]           nabs [4];
  logic [NW-1:0]        num_nxt [4];
  ami_pkg::ctl_t        ctl_nxt;

  assign det_nxt = (DW+1)'(pa_r) - (DW+1)'(pb_r);

  // Numerators of the adjugate; the diagonal case falls out with zero off-diagonals.
  always_comb begin
    nsg[0] = (W+1)'(yy2_r);
    nsg[1] = -(W+1)'(xy2_r);
    nsg[2] = -(W+1)'(yx2_r);
    nsg[3] = (W+1)'(xx2_r);
    dabs = det_r[DW] ? (DW+1)'(-det_r) : (DW+1)'(det_r);
    den_nxt = dabs[DW-1:0];
    ctl_nxt.singular = (det_r == '0);
    for (int k = 0; k < 4; k++) begin
      nabs[k] = nsg[k][W] ? (W+1)'(-nsg[k]) : (W+1)'(nsg[k]);
      num_nxt[k] = {nabs[k][W-1:0], {(2*F){1'b0}}};
      ctl_nxt.neg[k] = nsg[k][W] ^ det_r[DW];
      ctl_nxt.big[k] = CW'(num_nxt[k]) >= (CW'(den_nxt) << W);
    end
  end

  // Valid bits for the three stages.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else if (en) begin
      v1_r <= vld_in;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (en) begin
      pa_r  <= DW'(xx) * DW'(yy);
      pb_r  <= DW'(xy) * DW'(yx);
      xx1_r <= xx;
      xy1_r <= xy;
      yx1_r <= yx;
      yy1_r <= yy;
      sb1_r <= {ty, tx};
      det_r <= det_nxt;
      xx2_r <= xx1_r;
      xy2_r <= xy1_r;
      yx2_r <= yx1_r;
      yy2_r <= yy1_r;
      sb2_r <= sb1_r;
      num_r <= num_nxt;
      den_r <= den_nxt;
      ctl_r <= ctl_nxt;
      sb3_r <= sb2_r;
    end
  end

  assign vld_out = v3_r;
  assign num_out = num_r;
  assign den_out = den_r;
  assign ctl_out = ctl_r;
  assign sb_out  = sb3_r;

endmodule

`default_nettype wire

// ===== sv/ami_div.sv =====
// Four-lane restoring divider with one quotient bit per register stage.
`default_nettype none

module ami_div #(
  parameter int W = 32,
  parameter int F = 16
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             en,
  input  wire logic             vld_in,
  input  wire logic [W+2*F-1:0] num_in [4],
  input  wire logic [2*W-1:0]   den_in,
  input  wire ami_pkg::ctl_t    ctl_in,
  input  wire logic [2*W-1:0]   sb_in,
  output logic                  vld_out,
  output logic [W-1:0]          quo_out [4],
  output ami_pkg::ctl_t         ctl_out,
  output logic [2*W-1:0]        sb_out
);

  localparam int NW = W + 2*F;
  localparam int DW = 2*W;
  localparam int CW = 3*W;

  logic                vld_r [W];
  logic [NW-1:0]       rem_r [W][4];
  logic [W-1:0]        quo_r [W][4];
  logic [DW-1:0]       den_r [W];
  ami_pkg::ctl_t       ctl_r [W];
  logic [DW-1:0]       sb_r  [W];

  for (genvar s = 0; s < W; s++) begin : g_stage
    localparam int BIT = W - 1 - s;

    logic          vld_i;
    logic [NW-1:0] rem_i [4];
    logic [W-1:0]  quo_i [4];
    logic [DW-1:0] den_i;
    ami_pkg::ctl_t ctl_i;
    logic [DW-1:0] sb_i;
    logic [CW-1:0] dsh;
    logic [CW-1:0] diff [4];
    logic          ge [4];
    logic [NW-1:0] rem_nxt [4];
    logic [W-1:0]  quo_nxt [4];

    if (s == 0) begin : g_first
      assign vld_i = vld_in;
      assign rem_i = num_in;
      assign den_i = den_in;
      assign ctl_i = ctl_in;
      assign sb_i  = sb_in;
      always_comb begin
        for (int k = 0; k < 4; k++) begin
          quo_i[k] = '0;
        end
      end
    end else begin : g_next
      assign vld_i = vld_r[s-1];
      assign rem_i = rem_r[s-1];
      assign quo_i = quo_r[s-1];
      assign den_i = den_r[s-1];
      assign ctl_i = ctl_r[s-1];
      assign sb_i  = sb_r[s-1];
    end

    // Trial subtraction of the shifted divisor in each lane.
    assign dsh = CW'(den_i) << BIT;
    always_comb begin
      for (int k = 0; k < 4; k++) begin
        diff[k]    = CW'(rem_i[k]) - dsh;
        ge[k]      = CW'(rem_i[k]) >= dsh;
        rem_nxt[k] = ge[k] ? diff[k][NW-1:0] : rem_i[k];
        quo_nxt[k] = quo_i[k] | (W'(ge[k]) << BIT);
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[s] <= 1'b0;
      end else if (en) begin
        vld_r[s] <= vld_i;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[s] <= rem_nxt;
        quo_r[s] <= quo_nxt;
        den_r[s] <= den_i;
        ctl_r[s] <= ctl_i;
        sb_r[s]  <= sb_i;
      end
    end
  end

  assign vld_out = vld_r[W-1];
  assign quo_out = quo_r[W-1];
  assign ctl_out = ctl_r[W-1];
  assign sb_out  = sb_r[W-1];

endmodule

`default_nettype wire

// ===== sv/ami_trans.sv =====
// Quotient saturation, inverse translation and status: four register stages.
`default_nettype none

module ami_trans #(
  parameter int W = 32,
  parameter int F = 16
) (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            en,
  input  wire logic            vld_in,
  input  wire logic [W-1:0]    quo_in [4],
  input  wire ami_pkg::ctl_t   ctl_in,
  input  wire logic [2*W-1:0]  sb_in,
  output logic                 vld_out,
  output logic [W-1:0]         res_out [6],
  output ami_pkg::status_t     status_out
);

  localparam int MW = 2*W + 2;
  localparam int DW = 2*W;

  // Applies a sign to a magnitude and clamps it; the top bit flags a clamp.
  function automatic logic [W:0] sat_fn(input logic neg, input logic [MW-1:0] m);
    logic [MW-1:0] lim;
    logic [MW-1:0] v;
    lim = MW'(1) << (W-1);
    v   = MW'(0) - m;
    if (neg) begin
      if (m > lim) begin
        sat_fn = {1'b1, 1'b1, {(W-1){1'b0}}};
      end else begin
        sat_fn = {1'b0, v[W-1:0]};
      end
    end else begin
      if (m >= lim) begin
        sat_fn = {1'b1, 1'b0, {(W-1){1'b1}}};
      end else begin
        sat_fn = {1'b0, m[W-1:0]};
      end
    end
  endfunction

  // Stage A: saturated inverse elements.
  logic                vA_r;
  logic signed [W-1:0] rA_r [4];
  logic                ovfA_r, singA_r;
  logic signed [W-1:0] txA_r, tyA_r;

  // Stage B: translation products.
  logic                 vB_r;
  logic signed [DW-1:0] pB_r [4];
  logic signed [W-1:0]  rB_r [4];
  logic                 ovfB_r, singB_r;

  // Stage C: product sums.
  logic                 vC_r;
  logic signed [DW:0]   sC_r [2];
  logic signed [W-1:0]  rC_r [4];
  logic                 ovfC_r, singC_r;

  // Stage D: output register.
  logic                 vD_r;
  logic [W-1:0]         res_r [6];
  ami_pkg::status_t     st_r;

  logic [W:0]           satA [4];
  logic [W-1:0]         rA_nxt [4];
  logic                 ovfA_nxt;
  logic [MW-1:0]        magD [2];
  logic [W:0]           satD [2];
  logic                 ovfD;
  logic [W-1:0]         res_nxt [6];
  ami_pkg::status_t     st_nxt;

  always_comb begin
    ovfA_nxt = 1'b0;
    for (int k = 0; k < 4; k++) begin
      satA[k] = sat_fn(ctl_in.neg[k], ctl_in.big[k] ? {MW{1'b1}} : MW'(quo_in[k]));
      rA_nxt[k] = ctl_in.singular ? '0 : satA[k][W-1:0];
      ovfA_nxt = ovfA_nxt | satA[k][W];
    end
    ovfA_nxt = ovfA_nxt & ~ctl_in.singular;
  end

  // The translation is the negated sum, so its sign is the opposite of the sum's.
  always_comb begin
    ovfD = ovfC_r;
    for (int k = 0; k < 2; k++) begin
      magD[k] = sC_r[k][DW] ? MW'(-sC_r[k]) : MW'(sC_r[k]);
      satD[k] = sat_fn(!sC_r[k][DW] && (sC_r[k] != '0), magD[k] >> F);
      ovfD = ovfD | satD[k][W];
    end
    for (int k = 0; k < 4; k++) begin
      res_nxt[k] = rC_r[k];
    end
    res_nxt[4] = singC_r ? '0 : satD[0][W-1:0];
    res_nxt[5] = singC_r ? '0 : satD[1][W-1:0];
    if (singC_r) begin
      st_nxt = ami_pkg::ST_SINGULAR;
    end else if (ovfD) begin
      st_nxt = ami_pkg::ST_OVERFLOW;
    end else begin
      st_nxt = ami_pkg::ST_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vA_r <= 1'b0;
      vB_r <= 1'b0;
      vC_r <= 1'b0;
      vD_r <= 1'b0;
    end else if (en) begin
      vA_r <= vld_in;
      vB_r <= vA_r;
      vC_r <= vB_r;
      vD_r <= vC_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 4; k++) begin
        rA_r[k] <= rA_nxt[k];
      end
      ovfA_r  <= ovfA_nxt;
      singA_r <= ctl_in.singular;
      txA_r   <= sb_in[W-1:0];
      tyA_r   <= sb_in[DW-1:W];
      pB_r[0] <= DW'(txA_r) * DW'(rA_r[0]);
      pB_r[1] <= DW'(tyA_r) * DW'(rA_r[2]);
      pB_r[2] <= DW'(txA_r) * DW'(rA_r[1]);
      pB_r[3] <= DW'(tyA_r) * DW'(rA_r[3]);
      rB_r    <= rA_r;
      ovfB_r  <= ovfA_r;
      singB_r <= singA_r;
      sC_r[0] <= (DW+1)'(pB_r[0]) + (DW+1)'(pB_r[1]);
      sC_r[1] <= (DW+1)'(pB_r[2]) + (DW+1)'(pB_r[3]);
      rC_r    <= rB_r;
      ovfC_r  <= ovfB_r;
      singC_r <= singB_r;
      res_r   <= res_nxt;
      st_r    <= st_nxt;
    end
  end

  assign vld_out    = vD_r;
  assign res_out    = res_r;
  assign status_out = st_r;

endmodule

`default_nettype wire

// ===== sv/affine_matrix_invert.sv =====
// Top level of the pipelined 2D affine matrix inverter.
//
// One word on the input stream is an affine matrix: xx, xy, yx, yy, tx and ty,
// signed fixed point with FRAC_BITS fraction bits. Each word gives exactly one
// result word: the inverse matrix and translation, saturated, with a status
// code on out_tuser (ok, singular with all fields zero, or saturated).
// The block is a single pipeline of VALUE_WIDTH + 7 register stages; the
// determinant takes three
// stages, the divider one stage per quotient bit and the translation four.
// A new word is taken in every cycle while the output is not stalled, so throughput is one matrix per clock.
// The last stage is the output register. When it holds a word that the
// receiver does not take, the whole pipeline stops and in_tready drops; no
// word is lost or repeated, and it resumes as soon as out_tready rises.
// Reset (rst_n low, synchronous) empties the pipeline; no words are pending
// afterwards and the block needs no further set-up.
`default_nettype none

module affine_matrix_invert #(
  parameter int FRAC_BITS   = 16,
  parameter int VALUE_WIDTH = 32
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  input  wire logic                                 in_tvalid,
  output logic                                      in_tready,
  // Fields from bit 0 up: xx, xy, yx, yy, tx, ty, then zero fill.
  input  wire logic [((6*VALUE_WIDTH+7)/8)*8-1:0]   in_tdata,
  output logic                                      out_tvalid,
  input  wire logic                                 out_tready,
  // Fields from bit 0 up: xx, xy, yx, yy, tx, ty, then zero fill.
  output logic [((6*VALUE_WIDTH+7)/8)*8-1:0]        out_tdata,
  // Field: status.
  output logic [1:0]                                out_tuser
);

  localparam int W  = VALUE_WIDTH;
  localparam int F  = FRAC_BITS;
  localparam int NW = W + 2*F;
  localparam int TW = ((6*W+7)/8)*8;

  logic               en;
  logic               prep_vld, div_vld;
  logic [NW-1:0]      prep_num [4];
  logic [2*W-1:0]     prep_den, prep_sb, div_sb;
  ami_pkg::ctl_t      prep_ctl, div_ctl;
  logic [W-1:0]       div_quo [4];
  logic [W-1:0]       res [6];
  ami_pkg::status_t   status;

  // The pipeline moves whenever the output register is free or being emptied.
  assign en        = !out_tvalid || out_tready;
  assign in_tready = en;

  ami_prep #(.W(W), .F(F)) u_prep (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .vld_in  (in_tvalid),
    .xx      (in_tdata[0*W +: W]),
    .xy      (in_tdata[1*W +: W]),
    .yx      (in_tdata[2*W +: W]),
    .yy      (in_tdata[3*W +: W]),
    .tx      (in_tdata[4*W +: W]),
    .ty      (in_tdata[5*W +: W]),
    .vld_out (prep_vld),
    .num_out (prep_num),
    .den_out (prep_den),
    .ctl_out (prep_ctl),
    .sb_out  (prep_sb)
  );

  ami_div #(.W(W), .F(F)) u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .vld_in  (prep_vld),
    .num_in  (prep_num),
    .den_in  (prep_den),
    .ctl_in  (prep_ctl),
    .sb_in   (prep_sb),
    .vld_out (div_vld),
    .quo_out (div_quo),
    .ctl_out (div_ctl),
    .sb_out  (div_sb)
  );

  ami_trans #(.W(W), .F(F)) u_trans (
    .clk        (clk),
    .rst_n      (rst_n),
    .en         (en),
    .vld_in     (div_vld),
    .quo_in     (div_quo),
    .ctl_in     (div_ctl),
    .sb_in      (div_sb),
    .vld_out    (out_tvalid),
    .res_out    (res),
    .status_out (status)
  );

  assign out_tdata = TW'({res[5], res[4], res[3], res[2], res[1], res[0]});
  assign out_tuser = status;

  // A singular matrix always comes out with every field cleared.
  a_singular_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser == ami_pkg::ST_SINGULAR) |-> (out_tdata == '0))
    else $error("singular result with nonzero fields");

  // A held result must stall the input side in the same cycle.
  a_stall_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |-> !in_tready)
    else $error("input accepted while output stalled");

  // A word held on the output keeps its status while stalled.
  a_status_held: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> $stable(out_tuser))
    else $error("status changed during stall");

endmodule

`default_nettype wire

// ===== verif/ami_checker.sv =====
// Result checker for the affine matrix inverter: predicts each inverse and compares it.
`default_nettype none

module ami_checker (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_tvalid,
  input  wire logic         in_tready,
  input  wire logic [191:0] in_tdata,
  input  wire logic         out_tvalid,
  input  wire logic         out_tready,
  input  wire logic [191:0] out_tdata,
  input  wire logic [1:0]   out_tuser,
  output int                fail_count,
  output int                pending
);

  typedef logic signed [127:0] wide_t;

  typedef struct packed {
    logic [191:0]     fields;
    ami_pkg::status_t status;
  } inverse_t;

  inverse_t inverse_q[$];
  int       words_seen;

  // Applies a sign to a magnitude and clamps it to the signed 32-bit range.
  function automatic logic [31:0] clamp(input bit negative, input logic [127:0] mag,
                                        inout bit ovf);
    if (negative) begin
      if (mag > 128'h8000_0000) begin
        ovf = 1'b1;
        return 32'h8000_0000;
      end
      return -mag[31:0];
    end
    if (mag >= 128'h8000_0000) begin
      ovf = 1'b1;
      return 32'h7fff_ffff;
    end
    return mag[31:0];
  endfunction

  function automatic logic [127:0] magnitude(input wide_t v);
    return (v < 0) ? -v : v;
  endfunction

  // Quotient of magnitudes truncated toward zero, sign applied afterwards.
  function automatic logic [31:0] quotient(input wide_t num, input wide_t den, inout bit ovf);
    logic [127:0] q;
    q = magnitude(num) / magnitude(den);
    return clamp((num < 0) != (den < 0), q, ovf);
  endfunction

  // Inverse translation term: -(a*b + c*d), scaled down toward zero.
  function automatic logic [31:0] offset(input wide_t a, input wide_t b, input wide_t c,
                                         input wide_t d, inout bit ovf);
    wide_t s;
    s = -(a * b + c * d);
    return clamp(s < 0, magnitude(s) >> 16, ovf);
  endfunction

  function automatic wide_t widen(input logic [31:0] v);
    wide_t w;
    w = $signed(v);
    return w;
  endfunction

  function automatic inverse_t invert_matrix(input logic [191:0] w);
    wide_t    xx, xy, yx, yy, tx, ty, det;
    wide_t    zero;
    logic [31:0] r [6];
    bit       ovf;
    inverse_t res;
    xx = widen(w[31:0]);
    xy = widen(w[63:32]);
    yx = widen(w[95:64]);
    yy = widen(w[127:96]);
    tx = widen(w[159:128]);
    ty = widen(w[191:160]);
    zero = '0;
    ovf = 1'b0;
    foreach (r[k]) r[k] = '0;
    res.status = ami_pkg::ST_OK;
    if (xy == 0 && yx == 0) begin
      // Diagonal matrix: reciprocals of the two diagonal elements.
      if (xx == 0 || yy == 0) begin
        res.status = ami_pkg::ST_SINGULAR;
      end else begin
        r[0] = quotient(wide_t'(1) <<< 32, xx, ovf);
        r[3] = quotient(wide_t'(1) <<< 32, yy, ovf);
        r[4] = offset(tx, widen(r[0]), ty, zero, ovf);
        r[5] = offset(tx, zero, ty, widen(r[3]), ovf);
      end
    end else begin
      det = xx * yy - xy * yx;
      if (det == 0) begin
        res.status = ami_pkg::ST_SINGULAR;
      end else begin
        r[0] = quotient(yy <<< 32, det, ovf);
        r[1] = quotient((-xy) <<< 32, det, ovf);
        r[2] = quotient((-yx) <<< 32, det, ovf);
        r[3] = quotient(xx <<< 32, det, ovf);
        // The clamped elements feed the translation.
        r[4] = offset(tx, widen(r[0]), ty, widen(r[2]), ovf);
        r[5] = offset(tx, widen(r[1]), ty, widen(r[3]), ovf);
      end
    end
    if (res.status == ami_pkg::ST_OK && ovf) res.status = ami_pkg::ST_OVERFLOW;
    res.fields = {r[5], r[4], r[3], r[2], r[1], r[0]};
    return res;
  endfunction

  task automatic report(input string what);
    $display("MISMATCH word %0d: %s", words_seen, what);
    fail_count++;
  endtask

  // Predict on every accepted input word; compare every accepted result word.
  always @(posedge clk) begin
    inverse_t want;
    if (rst_n) begin
      if (in_tvalid && in_tready) inverse_q.push_back(invert_matrix(in_tdata));
      if (out_tvalid && out_tready) begin
        if (inverse_q.size() == 0) begin
          report("result word with no matrix outstanding");
        end else begin
          want = inverse_q.pop_front();
          for (int k = 0; k < 6; k++) begin
            if (out_tdata[32*k +: 32] !== want.fields[32*k +: 32])
              report($sformatf("field %0d got %h expected %h", k,
                               out_tdata[32*k +: 32], want.fields[32*k +: 32]));
          end
          if (out_tuser !== want.status)
            report($sformatf("status got %0d expected %0d", out_tuser, want.status));
        end
        words_seen++;
      end
      pending <= inverse_q.size();
    end
  end

endmodule

`default_nettype wire

// ===== verif/testbench.sv =====
// Stimulus and verdict for the affine matrix inverter, with the checker beside it.
`default_nettype none

module testbench;

  localparam int CYCLE_LIMIT = 400000;

  logic         clk = 1'b0;
  logic         rst_n = 1'b0;
  logic         in_tvalid = 1'b0;
  logic         in_tready;
  logic [191:0] in_tdata = '0;
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  logic [191:0] out_tdata;
  logic [1:0]   out_tuser;
  int           fail_count;
  int           pending;
  int           gap_pct = 0;
  int           stall_pct = 0;
  bit           hold_request = 1'b0;
  bit           hold_active = 1'b0;
  int           cycles = 0;
  int           n_diag = 0, n_general = 0, n_singular = 0, n_wild = 0;

  affine_matrix_invert uut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser)
  );

  ami_checker check (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser), .fail_count(fail_count), .pending(pending)
  );

  always #1 clk = ~clk;

  // Run limit.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("affine_matrix_invert verification failed");
      $finish;
    end
  end

  // Long receiver hold-off, counted in its own process.
  initial begin
    wait (hold_request);
    @(posedge clk);
    hold_active <= 1'b1;
    repeat (300) @(posedge clk);
    hold_active <= 1'b0;
  end

  // Receiver readiness.
  always @(posedge clk) begin
    if (!rst_n || hold_active) out_tready <= 1'b0;
    else out_tready <= ($urandom_range(99) >= stall_pct);
  end

  // Offers one matrix word, with a random gap first, and waits until it is taken.
  task automatic send_matrix(input logic [31:0] xx, xy, yx, yy, tx, ty);
    if ($urandom_range(99) < gap_pct) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(3, 1)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {ty, tx, yy, yx, xy, xx};
    @(negedge clk);
    while (!in_tready) @(negedge clk);
    @(posedge clk);
  endtask

  function automatic logic [31:0] small_q(input int span);
    return $signed($urandom_range(2 * span, 0)) - span;
  endfunction

  // One random matrix; mostly well-formed shapes, some raw noise.
  task automatic random_matrix();
    logic [31:0] a, b, c, d;
    int kind;
    kind = $urandom_range(9);
    case (kind)
      0, 1: begin
        n_diag++;
        send_matrix((kind == 0 && $urandom_range(7) == 0) ? 32'd0 : small_q(32'h40000),
                    '0, '0, small_q(32'h40000), $urandom, $urandom);
      end
      2: begin
        // Rank-one matrix built from two factor pairs: determinant is zero.
        n_singular++;
        a = small_q(30000); b = small_q(30000); c = small_q(30000); d = small_q(30000);
        send_matrix($signed(a) * $signed(c), $signed(a) * $signed(d),
                    $signed(b) * $signed(c), $signed(b) * $signed(d), $urandom, $urandom);
      end
      3, 4: begin
        n_wild++;
        send_matrix($urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
      end
      5: begin
        n_general++;
        send_matrix(small_q(300), small_q(300), small_q(300), small_q(300),
                    $urandom, $urandom);
      end
      default: begin
        n_general++;
        send_matrix(small_q(32'h30000), small_q(32'h30000), small_q(32'h30000),
                    small_q(32'h30000), small_q(32'h1000000), small_q(32'h1000000));
      end
    endcase
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed words: identities, extremes, zero diagonals and singular forms.
    send_matrix(32'h10000, 0, 0, 32'h10000, 0, 0);
    send_matrix(32'h10000, 0, 0, 32'h10000, 32'h7fffffff, 32'h80000000);
    send_matrix(32'hffff0000, 0, 0, 32'hffff0000, 32'h12345678, 32'hfedcba98);
    send_matrix(0, 0, 0, 0, 32'hffffffff, 32'hffffffff);
    send_matrix(0, 0, 0, 32'h10000, 1, 1);
    send_matrix(32'h10000, 0, 0, 0, 1, 1);
    send_matrix(1, 0, 0, 1, 1, 1);
    send_matrix(32'hffffffff, 0, 0, 32'hffffffff, 0, 0);
    send_matrix(32'h80000000, 0, 0, 32'h80000000, 32'h80000000, 32'h80000000);
    send_matrix(32'h7fffffff, 0, 0, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff);
    send_matrix(32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000, 5, 5);
    send_matrix(32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 5, 5);
    send_matrix(32'h7fffffff, 32'h80000000, 32'h80000000, 32'h7fffffff, 0, 0);
    send_matrix(0, 32'h10000, 32'h10000, 0, 32'h30000, 32'hfffd0000);
    send_matrix(0, 32'h10000, 32'hffff0000, 0, 32'h7fffffff, 32'h80000000);
    send_matrix(32'h20000, 32'h10000, 32'h40000, 32'h20000, 1, 2);
    send_matrix(0, 1, 0, 0, 0, 0);
    send_matrix(0, 0, 1, 0, 0, 0);
    send_matrix(1, 1, 1, 2, 32'h80000000, 32'h7fffffff);
    send_matrix(32'hffffffff, 32'hffffffff, 32'hffffffff, 32'hffffffff, 32'hffffffff, 0);
    send_matrix(32'h8000, 0, 0, 32'h18000, 32'h55555555, 32'haaaaaaaa);

    // Random phases with different amounts of idling on each side.
    for (int phase = 0; phase < 5; phase++) begin
      case (phase)
        0: begin gap_pct = 0;  stall_pct = 0;  end
        1: begin gap_pct = 49; stall_pct = 0;  end
        2: begin gap_pct = 0;  stall_pct = 49; end
        3: begin gap_pct = 22; stall_pct = 22; end
        default: begin gap_pct = 0; stall_pct = 0; hold_request = 1'b1; end
      endcase
      repeat (166) random_matrix();
    end
    in_tvalid <= 1'b0;

    while (pending != 0 || hold_active) @(posedge clk);
    repeat (60) @(posedge clk);
    $display("Covered %0d diagonal, %0d general, %0d rank-one and %0d raw random matrices,",
             n_diag, n_general, n_singular, n_wild);
    $display("plus directed extremes, under four idling mixes and one long receiver hold-off.");
    if (fail_count == 0) begin
      $display("affine_matrix_invert verification clean");
    end else begin
      $display("affine_matrix_invert verification failed");
    end
    $finish;
  end

endmodule

`default_nettype wire
